### sv/assert_macros.svh
// Assertion macros for the checker file of this block.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A concurrent property with a label and a message.
`define VKR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge.
`define VKR_NEVER(lbl, cond, msg) \
    `VKR_ASSERT(lbl, !(cond), msg)

`endif

### sv/vkr_pkg.sv
// Package for the Vigenere key recovery and decryption unit.
// Holds widths, character constants, the key store request type, letter and length helpers.
// No dependencies.
package vkr_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 5;
    localparam int CFG_W   = 7;
    localparam int KEY_MAX = 64;
    localparam int KEY_AW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LEN_W   = KEY_AW + 1;

    localparam logic [DIGIT_W-1:0] ALPHA   = DIGIT_W'(26);
    localparam logic [CHAR_W-1:0]  UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0]  UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0]  LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0]  LOWER_Z = 8'h7A;

    typedef struct packed {
        logic               we;
        logic [KEY_AW-1:0]  waddr;
        logic [DIGIT_W-1:0] wdata;
        logic               re;
        logic [KEY_AW-1:0]  raddr;
    } t_key_req;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= UPPER_A) && (c <= UPPER_Z);
    endfunction

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= LOWER_A) && (c <= LOWER_Z);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return is_upper(c) || is_lower(c);
    endfunction

    // Alphabet position of a letter; the caller makes sure c is a letter.
    function automatic logic [DIGIT_W-1:0] letter_pos(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = is_upper(c) ? (c - UPPER_A) : (c - LOWER_A);
        return d[DIGIT_W-1:0];
    endfunction

    // Key length clamped to the range 1 to KEY_MAX.
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] n;
        if (v == '0) begin
            n = LEN_W'(1);
        end else if (int'(v) > KEY_MAX) begin
            n = LEN_W'(KEY_MAX);
        end else begin
            n = LEN_W'(v);
        end
        return n;
    endfunction

endpackage

### sv/vkr_ctrl.sv
// Key length register, learn counter and key index of the Vigenere unit.
// Makes key writes for new digits and reads for decrypt letters. Depends on vkr_pkg.
module vkr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vkr_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_accept,
    input  logic                        i_mode,
    input  logic                        i_line_start,
    input  logic [vkr_pkg::CHAR_W-1:0]  i_char_a,
    input  logic [vkr_pkg::CHAR_W-1:0]  i_char_b,
    output vkr_pkg::t_key_req           o_req
);
    import vkr_pkg::*;

    logic [CFG_W-1:0]   r_key_length;
    logic [LEN_W-1:0]   r_learn_count, n_learn_count;
    logic [KEY_AW-1:0]  r_key_index, n_key_index;

    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   lc;
    logic [KEY_AW-1:0]  ki;
    logic [KEY_AW-1:0]  ridx;
    logic [LEN_W-1:0]   nidx_w;
    logic [KEY_AW-1:0]  nidx;
    logic [DIGIT_W-1:0] pa, pb, digit;
    logic               learn_wr;
    logic               dec_letter;

    always_comb begin
        len = eff_len(r_key_length);
        lc  = i_line_start ? '0 : r_learn_count;
        ki  = i_line_start ? '0 : r_key_index;
        pa  = letter_pos(i_char_a);
        pb  = letter_pos(i_char_b);
        // The difference wraps modulo 32, which is exact since the true digit is 0 to 25.
        digit = (pb >= pa) ? (pb - pa) : (pb + ALPHA - pa);

        learn_wr   = i_accept && !i_mode && is_letter(i_char_a) && is_letter(i_char_b)
                     && (lc < len);
        dec_letter = i_accept && i_mode && is_letter(i_char_a);

        // A stale index left over from a longer key wraps to the start.
        ridx   = ({1'b0, ki} >= len) ? '0 : ki;
        nidx_w = {1'b0, ridx} + LEN_W'(1);
        nidx   = (nidx_w >= len) ? '0 : nidx_w[KEY_AW-1:0];

        n_learn_count = r_learn_count;
        n_key_index   = r_key_index;
        if (i_accept && !i_mode) begin
            n_learn_count = learn_wr ? (lc + LEN_W'(1)) : lc;
        end
        if (i_accept && i_mode) begin
            n_key_index = dec_letter ? nidx : ki;
        end

        o_req.we    = learn_wr;
        o_req.waddr = lc[KEY_AW-1:0];
        o_req.wdata = digit;
        o_req.re    = dec_letter;
        o_req.raddr = ridx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length  <= CFG_W'(1);
            r_learn_count <= '0;
            r_key_index   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key_length <= i_cfg_data;
            end
            r_learn_count <= n_learn_count;
            r_key_index   <= n_key_index;
        end
    end

endmodule

### sv/vkr_key_store.sv
// Key digit memory of the Vigenere unit: one write port, one registered read port.
// Depends on vkr_pkg.
module vkr_key_store (
    input  logic                        i_clk,
    input  vkr_pkg::t_key_req           i_req,
    output logic [vkr_pkg::DIGIT_W-1:0] o_rd_data
);
    import vkr_pkg::*;

    logic [DIGIT_W-1:0] r_mem [KEY_MAX];
    logic [DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/vkr_out_stage.sv
// Letter shift and output register of the Vigenere unit.
// Shifts a letter back by its key digit, keeps case, and holds the result until taken.
// Depends on vkr_pkg.
module vkr_out_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_letter,
    input  logic [vkr_pkg::CHAR_W-1:0]  i_char,
    input  logic [vkr_pkg::DIGIT_W-1:0] i_digit,
    input  logic                        i_stall,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [vkr_pkg::CHAR_W-1:0]  o_char
);
    import vkr_pkg::*;

    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic [DIGIT_W-1:0] k, pa, p;
    logic [CHAR_W-1:0]  base;
    logic [CHAR_W-1:0]  res;

    always_comb begin
        k    = (i_digit >= ALPHA) ? (i_digit - ALPHA) : i_digit;
        pa   = letter_pos(i_char);
        p    = (pa >= k) ? (pa - k) : (pa + ALPHA - k);
        base = is_upper(i_char) ? UPPER_A : LOWER_A;
        res  = i_letter ? (base + CHAR_W'(p)) : i_char;
    end

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_char <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

### sv/vigenere_key_recover_decrypt_unit.sv
// Top level of the Vigenere key recovery and decryption unit.
// Ties the control, the key store and the output stage together. Depends on vkr_pkg.
//
// The unit takes one item per clock cycle unless its input is stalled. A decrypt
// result is registered in the middle stage and then in the output register before
// it is offered. A learn item (mode 0) whose plain and cipher
// bytes are both letters writes the key digit (cipher - plain) mod 26 into the key
// store at the learn count, until the effective key length is reached; it never
// yields a result. A decrypt item (mode 1) yields exactly one result: a letter is
// shifted back by the current key digit with its case kept and the key index
// advances, wrapping at the effective key length; any other byte passes unchanged.
// The effective key length is key_length clamped to 1..64. line_start clears the
// learn count or the key index before the item is used. All state updates and the
// key store access happen at the input transfer, so an item may follow the one
// before it in the very next cycle. Items keep flowing at one per cycle as long as
// results are taken; while the output is stalled, one result waits in the output
// register and one more decrypt item in the middle stage, and only when both are
// full does the input stall, in the same cycle as the output stall. Key digits that
// were never learned read back as undefined. key_length may be written only while
// the unit is idle.
module vigenere_key_recover_decrypt_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vkr_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic                        i_line_start,
    input  logic [vkr_pkg::CHAR_W-1:0]  i_char_a,
    input  logic [vkr_pkg::CHAR_W-1:0]  i_char_b,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [vkr_pkg::CHAR_W-1:0]  o_out_char
);
    import vkr_pkg::*;

    t_key_req           key_req;
    logic [DIGIT_W-1:0] key_digit;
    logic               accept;
    logic               out_free;

    // Middle stage: a decrypt item waiting for its key digit to reach the shifter.
    // Learn items finish at their input transfer and never occupy this stage.
    logic               r_s1_valid;
    logic               r_s1_letter;
    logic [CHAR_W-1:0]  r_s1_char;

    // The input stalls only when the middle stage is full and cannot move on,
    // which happens only while a finished result waits at the output.
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= i_mode;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_mode) begin
            r_s1_letter <= is_letter(i_char_a);
            r_s1_char   <= i_char_a;
        end
    end

    vkr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_line_start (i_line_start),
        .i_char_a     (i_char_a),
        .i_char_b     (i_char_b),
        .o_req        (key_req)
    );

    // The key digit is read at the input transfer and registered inside the store,
    // so it lines up with the middle stage and holds while that stage waits.
    vkr_key_store u_key_store (
        .i_clk     (i_clk),
        .i_req     (key_req),
        .o_rd_data (key_digit)
    );

    vkr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_letter (r_s1_letter),
        .i_char   (r_s1_char),
        .i_digit  (key_digit),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_char   (o_out_char)
    );

endmodule

### sv/vkr_checker.sv
// Port-level checker for the Vigenere unit, attached to the top level by bind.
// Depends on vkr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vkr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_mode,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [vkr_pkg::CHAR_W-1:0]  o_out_char
);
    import vkr_pkg::*;

    // A result that is not taken stays offered with the same byte.
    `VKR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char), "output result changed while stalled")

    // Nothing is offered in the first cycle after reset.
    `VKR_ASSERT(a_reset_empty, !$past(i_rst_n) |-> !o_out_valid, "result offered right after reset")

    // The input side waits only behind a stalled result.
    `VKR_NEVER(a_stall_cause, o_in_stall && !(o_out_valid && i_out_stall), "input stalled without a stalled result")

    // A decrypt transfer reaches the output through the middle stage when the output drains.
    `VKR_ASSERT(a_dec_latency, (i_in_valid && !o_in_stall && i_mode) ##1 !i_out_stall |=> o_out_valid, "decrypt result missing")

endmodule

bind vigenere_key_recover_decrypt_unit vkr_checker u_vkr_checker (.*);

### dv/tb_vigenere_key_recover_decrypt_unit.sv
// Testbench for vigenere_key_recover_decrypt_unit: directed and random traffic checked
// against a cycle-free model of key learning and decryption kept in this file.
// Depends on vkr_pkg and the unit's RTL; needs nothing else.
module tb_vigenere_key_recover_decrypt_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vkr_pkg::*;

    typedef logic [CHAR_W-1:0] t_char;

    localparam bit MODE_LEARN   = 1'b0;
    localparam bit MODE_DECRYPT = 1'b1;

    // Longest stretch of cycles without any transfer on either channel before the run
    // is declared hung. Random stalls at about one cycle in three never come close.
    localparam int HANG_LIMIT = 2000;
    // Results pass through the middle stage and the output register; learn items show
    // nothing, so waits before a register write or the end of the run use this margin.
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 850;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data   = '0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic              i_mode       = 1'b0;
    logic              i_line_start = 1'b0;
    t_char             i_char_a     = '0;
    t_char             i_char_b     = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    t_char             o_out_char;

    vigenere_key_recover_decrypt_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_line_start (i_line_start),
        .i_char_a     (i_char_a),
        .i_char_b     (i_char_b),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char)
    );

    // 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model state. It mirrors the unit's key store, learn count, key index and
    // key length register, and is advanced once per accepted input transfer.
    // ------------------------------------------------------------------------
    logic [DIGIT_W-1:0] key_digit [KEY_MAX];
    bit                 digit_learned [KEY_MAX];
    int unsigned        learned_cnt;
    int unsigned        cipher_pos;
    logic [CFG_W-1:0]   key_len_reg;

    // Plaintext bytes the unit still owes, oldest first.
    t_char plain_char_q [$];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  quiet_cycles   = 0;
    // While set, neither side inserts idle or stall cycles.
    bit  calm           = 1'b0;

    function automatic bit upper_letter(input t_char c);
        return (c >= UPPER_A) && (c <= UPPER_Z);
    endfunction

    function automatic bit lower_letter(input t_char c);
        return (c >= LOWER_A) && (c <= LOWER_Z);
    endfunction

    function automatic bit any_letter(input t_char c);
        return upper_letter(c) || lower_letter(c);
    endfunction

    function automatic int unsigned alpha_rank(input t_char c);
        return upper_letter(c) ? int'(c - UPPER_A) : int'(c - LOWER_A);
    endfunction

    // The register value clamped to 1..KEY_MAX, which is what the unit really cycles.
    function automatic int unsigned active_key_len();
        int unsigned n;
        n = 32'(key_len_reg);
        if (n < 1) n = 1;
        if (n > KEY_MAX) n = KEY_MAX;
        return n;
    endfunction

    // True when a decrypt of this byte would read a key digit that was never learned.
    // Such a read is undefined in the unit, so the stimulus steers around it.
    function automatic bit reads_unlearned(input bit line_start, input t_char c);
        int unsigned idx;
        if (!any_letter(c)) return 1'b0;
        idx = line_start ? 0 : cipher_pos;
        if (idx >= active_key_len()) idx = 0;
        return !digit_learned[idx];
    endfunction

    // Advance the model by one accepted item; a decrypt item queues its plaintext byte.
    function automatic void apply_item(input bit mode, input bit line_start,
                                       input t_char a, input t_char b);
        int unsigned len;
        int unsigned k;
        t_char       base;
        t_char       plain;
        len   = active_key_len();
        plain = a;
        if (mode == MODE_LEARN) begin
            if (line_start) learned_cnt = 0;
            if (any_letter(a) && any_letter(b) && learned_cnt < len) begin
                key_digit[learned_cnt]     = DIGIT_W'((alpha_rank(b) + 26 - alpha_rank(a)) % 26);
                digit_learned[learned_cnt] = 1'b1;
                learned_cnt                = (learned_cnt + 1) & 32'h7F;
            end
        end else begin
            if (line_start) cipher_pos = 0;
            if (any_letter(a)) begin
                base = upper_letter(a) ? UPPER_A : LOWER_A;
                // A stale index left over from a longer key starts over at the first digit.
                if (cipher_pos >= len) cipher_pos = 0;
                k     = key_digit[cipher_pos] % 26;
                plain = base + t_char'((alpha_rank(a) + 26 - k) % 26);
                cipher_pos++;
                if (cipher_pos >= len) cipher_pos = 0;
            end
            plain_char_q.insert(plain_char_q.size(), plain);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: takes each result transfer, compares it with the oldest
    // queued plaintext byte and drives a random stall for the next cycle.
    // Values read here are those sampled at the edge, since every flop and every
    // testbench drive updates in the nonblocking region.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (plain_char_q.size() == 0) begin
                $error("out_char: expected nothing, actual %02h", o_out_char);
                mismatch_count++;
            end else begin
                if (o_out_char !== plain_char_q[0]) begin
                    $error("out_char: expected %02h, actual %02h", plain_char_q[0], o_out_char);
                    mismatch_count++;
                end
                void'(plain_char_q.pop_front());
            end
        end
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 36);
    end

    // Hang detection: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Each task call starts on a clock edge, optionally idles, then
    // holds the item with valid high until the edge at which it transfers. Valid
    // is left high on return so that a following item can go out back to back.
    // ------------------------------------------------------------------------
    task automatic send_item(input bit mode, input bit line_start, input t_char a, input t_char b);
        while (!calm && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_line_start <= line_start;
        i_char_a     <= a;
        i_char_b     <= b;
        do @(posedge i_clk); while (o_in_stall);
        apply_item(mode, line_start, a, b);
        items_sent++;
    endtask

    // Writes key_length once the unit has drained. Learn items leave no result
    // behind, so a few extra cycles cover any that are still in flight.
    task automatic program_key_length(input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        while (plain_char_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        key_len_reg  = value;
    endtask

    function automatic t_char rand_letter();
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + t_char'($urandom_range(0, 25));
    endfunction

    function automatic t_char rand_non_letter();
        t_char c;
        do c = t_char'($urandom_range(0, 255)); while (any_letter(c));
        return c;
    endfunction

    // Sends a decrypt item, swapping a letter for a non-letter when the letter would
    // read an unlearned key digit.
    task automatic send_decrypt(input bit line_start, input t_char a, input t_char b);
        if (reads_unlearned(line_start, a)) a = rand_non_letter();
        send_item(MODE_DECRYPT, line_start, a, b);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Right after reset no digit exists, so only non-letters are decrypted. The
    // bytes sit at both ends of the range and just outside both letter ranges.
    task automatic test_passthrough_after_reset();
        send_decrypt(1'b0, 8'h00, 8'hFF);
        send_decrypt(1'b1, 8'hFF, 8'h00);
        send_decrypt(1'b0, 8'h40, 8'h41);
        send_decrypt(1'b0, 8'h7B, 8'h5A);
    endtask

    // Pairs with a non-letter on either side must not learn anything.
    task automatic test_learn_rejects();
        send_item(MODE_LEARN, 1'b1, 8'h31, "K");
        send_item(MODE_LEARN, 1'b0, "K", 8'h5B);
        send_item(MODE_LEARN, 1'b0, 8'h60, 8'h7B);
    endtask

    // The default length is one. A second pair once the key is full is dropped.
    task automatic test_single_digit_key();
        send_item(MODE_LEARN, 1'b1, "A", "Z");
        send_item(MODE_LEARN, 1'b0, "a", "b");
        send_decrypt(1'b0, "A", 8'h00);
        send_decrypt(1'b0, "z", 8'hFF);
        send_decrypt(1'b0, 8'h60, 8'h00);
    endtask

    // A three-digit key that mixes cases on both sides, decrypted past one wrap.
    task automatic test_multi_digit_key();
        program_key_length(7'd3);
        send_item(MODE_LEARN, 1'b1, "a", "d");
        send_item(MODE_LEARN, 1'b0, "Z", "a");
        send_item(MODE_LEARN, 1'b0, "m", "M");
        send_decrypt(1'b1, "D", 8'h00);
        send_decrypt(1'b0, "b", 8'h00);
        send_decrypt(1'b0, "Q", 8'h00);
        send_decrypt(1'b0, "x", 8'h00);
    endtask

    // The index now points at the second digit; shortening the key to one leaves
    // it out of range, and the next letter must start over at the first digit.
    task automatic test_stale_index();
        program_key_length(7'd1);
        send_decrypt(1'b0, "H", 8'h00);
        send_decrypt(1'b0, "h", 8'h00);
    endtask

    // A length of zero behaves like a length of one.
    task automatic test_length_clamp();
        program_key_length(7'd0);
        send_item(MODE_LEARN, 1'b1, "c", "q");
        send_item(MODE_LEARN, 1'b0, "q", "c");
        send_decrypt(1'b0, "c", 8'h00);
        send_decrypt(1'b1, "Y", 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Each round learns a key line (mostly letter pairs, a few
    // junk pairs, now and then a restart), decrypts a line of mostly letters,
    // and adds a short burst of fully random items.
    // ------------------------------------------------------------------------
    task automatic learn_line();
        int    n;
        bit    ls;
        t_char a;
        t_char b;
        n = active_key_len() + $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            ls = (i == 0) || ($urandom_range(0, 99) < 3);
            if ($urandom_range(0, 99) < 8) begin
                a = t_char'($urandom_range(0, 255));
                b = t_char'($urandom_range(0, 255));
            end else begin
                a = rand_letter();
                b = rand_letter();
            end
            send_item(MODE_LEARN, ls, a, b);
        end
    endtask

    task automatic decrypt_line();
        int    n;
        bit    ls;
        t_char a;
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            ls = (i == 0) || ($urandom_range(0, 99) < 4);
            a  = ($urandom_range(0, 99) < 85) ? rand_letter() : t_char'($urandom_range(0, 255));
            send_decrypt(ls, a, t_char'($urandom_range(0, 255)));
        end
    endtask

    task automatic noise_burst();
        bit    mode;
        bit    ls;
        t_char a;
        t_char b;
        repeat ($urandom_range(0, 3)) begin
            mode = 1'($urandom_range(0, 1));
            ls   = 1'($urandom_range(0, 1));
            a    = t_char'($urandom_range(0, 255));
            b    = t_char'($urandom_range(0, 255));
            if (mode == MODE_DECRYPT) send_decrypt(ls, a, b);
            else send_item(MODE_LEARN, ls, a, b);
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] fixed_lens [7] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd26};
        logic [CFG_W-1:0] len_val;
        int               start;
        int               phase;
        int               pick;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (phase < 7) begin
                len_val = fixed_lens[phase];
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) len_val = CFG_W'($urandom_range(1, 8));
                else if (pick < 90) len_val = CFG_W'($urandom_range(9, 64));
                else if (pick < 95) len_val = '0;
                else len_val = CFG_W'($urandom_range(65, 127));
            end
            program_key_length(len_val);
            // One phase runs with no idle or stall cycles on either side.
            calm = (phase == 5);
            repeat (2) begin
                learn_line();
                decrypt_line();
                noise_burst();
            end
            calm = 1'b0;
            phase++;
        end
    endtask

    initial begin
        for (int i = 0; i < KEY_MAX; i++) begin
            key_digit[i]     = '0;
            digit_learned[i] = 1'b0;
        end
        learned_cnt = 0;
        cipher_pos  = 0;
        key_len_reg = CFG_W'(1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough_after_reset();
        test_learn_rejects();
        test_single_digit_key();
        test_multi_digit_key();
        test_stale_index();
        test_length_clamp();
        test_random_traffic();

        // Drain: every owed byte must arrive, then a short margin catches strays.
        i_in_valid <= 1'b0;
        while (plain_char_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && plain_char_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
